>>> src/urpd_pkg.sv
// Shared types, codes and a helper function for the UDP receive port demultiplexer.
`timescale 1ns / 1ps

package urpd_pkg;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  data_byte;
      logic        last;
      logic [31:0] src_ip;
      logic [1:0]  rx_csum_flag;
      logic [15:0] bind_port;
      logic [3:0]  slot_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [15:0] local_port;
      logic [15:0] remote_port;
      logic [15:0] payload_length;
   } rsp_type;

   localparam logic [1:0] OP_BYTE   = 2'd0;
   localparam logic [1:0] OP_BIND   = 2'd1;
   localparam logic [1:0] OP_UNBIND = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_LEN   = 3'd1;
   localparam logic [2:0] ST_BAD_CSUM  = 3'd2;
   localparam logic [2:0] ST_NO_LISTEN = 3'd3;
   localparam logic [2:0] ST_PORT_USED = 3'd4;
   localparam logic [2:0] ST_NO_FREE   = 3'd5;
   localparam logic [2:0] ST_SLOT_BUSY = 3'd6;
   localparam logic [2:0] ST_UNBOUND   = 3'd7;

   localparam logic [1:0] FLAG_VALID   = 2'd1;
   localparam logic [1:0] FLAG_INVALID = 2'd2;

   localparam logic CSR_LOCAL_IP = 1'b0;
   localparam logic CSR_OFFLOAD  = 1'b1;

   localparam logic [15:0] HDR_BYTES  = 16'd8;
   localparam logic [15:0] UDP_PROTO  = 16'd17;
   localparam logic [3:0]  CSUM_LAST  = 4'd10;
   localparam int          QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      JOB_DGRAM  = 2'd0,
      JOB_BIND   = 2'd1,
      JOB_UNBIND = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [15:0]  byte_count;
      logic [15:0]  hw0;
      logic [15:0]  hw1;
      logic [15:0]  hw2;
      logic [15:0]  hw3;
      logic [15:0]  sum;
      logic [7:0]   odd_byte;
      logic [31:0]  src_ip;
      logic [1:0]   mac_flag;
      logic [15:0]  bind_port;
      logic [3:0]   slot_index;
   } job_type;

   // Ones'-complement 16-bit add with end-around carry.
   function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] w);
      logic [16:0] t;
      t = {1'b0, s} + {1'b0, w};
      return t[16] ? (t[15:0] + 16'd1) : t[15:0];
   endfunction

endpackage

>>> src/udp_receive_port_demux.sv
// Top level of the UDP receive port demultiplexer: configuration registers and wiring.
`timescale 1ns / 1ps

// Usage:
// The req_ channel takes one word per cycle while req_ready is high: a datagram
// byte (op 0), a port bind (op 1) or a slot unbind (op 2). Datagram bytes are
// absorbed at one per cycle while req_ready is high and produce a result word on
// rsp_ only with the byte marked last; bind and unbind always produce one result
// word. The csr_ port writes local_ip (index 0) and the checksum offload enable
// (index 1); the user must write them only while the block is idle, which the
// block itself does not enforce. A two-entry job queue separates the byte front
// end from the back end, so bytes keep flowing while the back end finishes an
// earlier verdict. A verdict passes through the checksum finish when computed and
// then the listener table search. A bind by port costs one table search; an
// ephemeral bind costs one search per candidate tried, at most PORT_SLOTS + 1
// candidates. The table search reads one slot per cycle through the port memory.
// Reset clears all listener bindings, the datagram state and the configuration,
// and the ephemeral pointer returns to EPHEMERAL_BASE. When rsp_ready stays low,
// the result register holds, the back end waits, and req_ready drops once the
// queue fills.

module udp_receive_port_demux #(
   parameter int PORT_SLOTS     = 16,
   parameter int EPHEMERAL_BASE = 49152
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  urpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output urpd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);
   import urpd_pkg::*;

   logic [31:0] local_ip_ff;
   logic        offload_ff;
   logic        push, full, pop, head_valid;
   job_type     push_job, head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
         offload_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOCAL_IP: local_ip_ff <= csr_wdata;
            CSR_OFFLOAD:  offload_ff  <= csr_wdata[0];
            default:      offload_ff  <= offload_ff;
         endcase
      end
   end

   urpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_job   (push_job),
      .queue_full (full)
   );

   urpd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   urpd_back #(
      .PORT_SLOTS     (PORT_SLOTS),
      .EPHEMERAL_BASE (EPHEMERAL_BASE)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .local_ip        (local_ip_ff),
      .rx_csum_offload (offload_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data)
   );

endmodule

>>> src/urpd_front.sv
// Front end: takes words, tracks the datagram header and running sum, queues jobs.
`timescale 1ns / 1ps

module urpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  urpd_pkg::req_type req_data,
   output logic              push,
   output urpd_pkg::job_type push_job,
   input  logic              queue_full
);
   import urpd_pkg::*;

   logic [15:0] bc_ff, bc_in;
   logic [15:0] hw_ff [4];
   logic [15:0] hw_in [4];
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  odd_ff, odd_in;
   logic [31:0] src_ff, src_in;
   logic [1:0]  flag_ff, flag_in;
   logic        accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      bc_in   = bc_ff;
      hw_in   = hw_ff;
      sum_in  = sum_ff;
      odd_in  = odd_ff;
      src_in  = src_ff;
      flag_in = flag_ff;
      if (bc_ff == 16'd0) begin
         src_in  = req_data.src_ip;
         flag_in = req_data.rx_csum_flag;
      end
      if (bc_ff < HDR_BYTES) begin
         if (!bc_ff[0]) begin
            hw_in[bc_ff[2:1]] = {req_data.data_byte, 8'h00};
         end else begin
            hw_in[bc_ff[2:1]][7:0] = req_data.data_byte;
         end
      end else if (bc_ff < hw_ff[2]) begin
         if (!bc_ff[0]) begin
            odd_in = req_data.data_byte;
         end else begin
            sum_in = oc_add(sum_ff, {odd_ff, req_data.data_byte});
         end
      end
      if (bc_ff != 16'hFFFF) begin
         bc_in = bc_ff + 16'd1;
      end
   end

   always_comb begin
      push_job            = '0;
      push_job.byte_count = bc_in;
      push_job.hw0        = hw_in[0];
      push_job.hw1        = hw_in[1];
      push_job.hw2        = hw_in[2];
      push_job.hw3        = hw_in[3];
      push_job.sum        = sum_in;
      push_job.odd_byte   = odd_in;
      push_job.src_ip     = src_in;
      push_job.mac_flag   = flag_in;
      push_job.bind_port  = req_data.bind_port;
      push_job.slot_index = req_data.slot_index;
      case (req_data.op)
         OP_BIND:   push_job.kind = JOB_BIND;
         OP_UNBIND: push_job.kind = JOB_UNBIND;
         default:   push_job.kind = JOB_DGRAM;
      endcase
      push = accept && ((req_data.op == OP_BIND) || (req_data.op == OP_UNBIND) ||
                        (req_data.op == OP_BYTE && req_data.last));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bc_ff   <= '0;
         hw_ff   <= '{default: '0};
         sum_ff  <= '0;
         odd_ff  <= '0;
         src_ff  <= '0;
         flag_ff <= '0;
      end else if (accept && req_data.op == OP_BYTE) begin
         src_ff  <= src_in;
         flag_ff <= flag_in;
         if (req_data.last) begin
            bc_ff  <= '0;
            hw_ff  <= '{default: '0};
            sum_ff <= '0;
            odd_ff <= '0;
         end else begin
            bc_ff  <= bc_in;
            hw_ff  <= hw_in;
            sum_ff <= sum_in;
            odd_ff <= odd_in;
         end
      end
   end

endmodule

>>> src/urpd_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module urpd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  urpd_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output urpd_pkg::job_type head_job
);
   import urpd_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   job_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ff, rd_ff;
   logic [CW-1:0]  count_ff;
   logic           do_pop;

   assign full       = (count_ff == CW'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

>>> src/urpd_back.sv
// Back end: checksum finish, port table search, bind and unbind, result register.
`timescale 1ns / 1ps

module urpd_back #(
   parameter int PORT_SLOTS     = 16,
   parameter int EPHEMERAL_BASE = 49152
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  urpd_pkg::job_type head_job,
   output logic              pop,
   input  logic [31:0]       local_ip,
   input  logic              rx_csum_offload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output urpd_pkg::rsp_type rsp_data
);
   import urpd_pkg::*;

   localparam int SW = (PORT_SLOTS > 1) ? $clog2(PORT_SLOTS) : 1;
   localparam int CW = $clog2(PORT_SLOTS + 1);
   localparam logic [15:0] EPH_BASE = 16'(EPHEMERAL_BASE);

   typedef enum logic [2:0] {
      S_IDLE, S_CSUM, S_SCAN, S_UNB_RD, S_FINISH
   } state_type;

   typedef enum logic [1:0] {
      M_LOOKUP, M_INUSE, M_EPH
   } mode_type;

   state_type       state_ff;
   mode_type        mode_ff;
   job_type         job_ff;
   logic [15:0]     tgt_ff, start_ff, eph_ff, total_ff, plen_ff;
   logic [3:0]      step_ff;
   logic [CW-1:0]   iss_ff;
   logic            cmp_vld_ff;
   logic [SW-1:0]   cmp_idx_ff;
   logic            valid_ff [PORT_SLOTS];
   rsp_type         res_ff, rsp_ff;
   logic            rsp_valid_ff;

   logic [15:0]     port_mem [PORT_SLOTS];
   logic [15:0]     rd_data_ff;
   logic [SW-1:0]   rd_addr, job_si, head_si;
   logic            mem_we;
   logic            hit, scan_end, head_in_range, job_in_range;
   logic [15:0]     term, sum_next, eph_adv;
   logic [16:0]     eph_inc;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pop       = (state_ff == S_IDLE) && head_valid;

   assign head_si       = SW'(head_job.slot_index);
   assign job_si        = SW'(job_ff.slot_index);
   assign head_in_range = int'(head_job.slot_index) < PORT_SLOTS;
   assign job_in_range  = int'(job_ff.slot_index) < PORT_SLOTS;

   assign hit      = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_data_ff == tgt_ff);
   assign scan_end = cmp_vld_ff && (cmp_idx_ff == SW'(PORT_SLOTS - 1));
   assign mem_we   = (state_ff == S_SCAN) && (mode_ff != M_LOOKUP) && scan_end && !hit;

   always_comb begin
      case (state_ff)
         S_SCAN:  rd_addr = SW'(iss_ff);
         S_IDLE:  rd_addr = head_si;
         default: rd_addr = job_si;
      endcase
   end

   // Next ephemeral candidate, wrapping back to the base.
   always_comb begin
      eph_inc = {1'b0, eph_ff} + 17'd1;
      eph_adv = (eph_inc[16] || eph_inc[15:0] < EPH_BASE) ? EPH_BASE : eph_inc[15:0];
   end

   // Trailing odd byte, UDP header words and pseudo-header terms, one per step.
   always_comb begin
      case (step_ff)
         4'd0:    term = job_ff.hw2[0] ? {job_ff.odd_byte, 8'h00} : 16'h0000;
         4'd1:    term = job_ff.hw0;
         4'd2:    term = job_ff.hw1;
         4'd3:    term = job_ff.hw2;
         4'd4:    term = job_ff.hw3;
         4'd5:    term = job_ff.src_ip[31:16];
         4'd6:    term = job_ff.src_ip[15:0];
         4'd7:    term = local_ip[31:16];
         4'd8:    term = local_ip[15:0];
         4'd9:    term = UDP_PROTO;
         default: term = job_ff.hw2;
      endcase
      sum_next = oc_add(total_ff, term);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         port_mem[job_si] <= tgt_ff;
      end
      rd_data_ff <= port_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '{default: 1'b0};
         eph_ff       <= EPH_BASE;
         cmp_vld_ff   <= 1'b0;
         iss_ff       <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  job_ff     <= head_job;
                  res_ff     <= '0;
                  iss_ff     <= '0;
                  cmp_vld_ff <= 1'b0;
                  res_ff.slot <= head_job.slot_index;
                  unique case (head_job.kind)
                     JOB_DGRAM: begin
                        res_ff.slot        <= '0;
                        res_ff.local_port  <= head_job.hw1;
                        res_ff.remote_port <= head_job.hw0;
                        tgt_ff             <= head_job.hw1;
                        mode_ff            <= M_LOOKUP;
                        plen_ff            <= head_job.hw2 - HDR_BYTES;
                        total_ff           <= head_job.sum;
                        step_ff            <= '0;
                        if (head_job.byte_count < HDR_BYTES || head_job.hw2 < HDR_BYTES ||
                            head_job.hw2 > head_job.byte_count) begin
                           res_ff.status <= ST_BAD_LEN;
                           state_ff      <= S_FINISH;
                        end else begin
                           res_ff.payload_length <= head_job.hw2 - HDR_BYTES;
                           if (head_job.hw3 == 16'd0) begin
                              state_ff <= S_SCAN;
                           end else if (rx_csum_offload &&
                                        head_job.mac_flag == FLAG_INVALID) begin
                              res_ff.status <= ST_BAD_CSUM;
                              state_ff      <= S_FINISH;
                           end else if (rx_csum_offload &&
                                        head_job.mac_flag == FLAG_VALID) begin
                              state_ff <= S_SCAN;
                           end else begin
                              state_ff <= S_CSUM;
                           end
                        end
                     end
                     JOB_BIND: begin
                        if (!head_in_range || valid_ff[head_si]) begin
                           res_ff.status <= ST_SLOT_BUSY;
                           state_ff      <= S_FINISH;
                        end else if (head_job.bind_port != 16'd0) begin
                           tgt_ff   <= head_job.bind_port;
                           mode_ff  <= M_INUSE;
                           state_ff <= S_SCAN;
                        end else begin
                           tgt_ff   <= eph_ff;
                           start_ff <= eph_ff;
                           eph_ff   <= eph_adv;
                           mode_ff  <= M_EPH;
                           state_ff <= S_SCAN;
                        end
                     end
                     JOB_UNBIND: begin
                        if (!head_in_range || !valid_ff[head_si]) begin
                           res_ff.status <= ST_UNBOUND;
                           state_ff      <= S_FINISH;
                        end else begin
                           state_ff <= S_UNB_RD;
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_CSUM: begin
               total_ff <= sum_next;
               step_ff  <= step_ff + 4'd1;
               if (step_ff == CSUM_LAST) begin
                  if (sum_next == 16'hFFFF) begin
                     state_ff <= S_SCAN;
                  end else begin
                     res_ff.status <= ST_BAD_CSUM;
                     state_ff      <= S_FINISH;
                  end
               end
            end
            S_SCAN: begin
               if (iss_ff < CW'(PORT_SLOTS)) begin
                  iss_ff     <= iss_ff + CW'(1);
                  cmp_vld_ff <= 1'b1;
                  cmp_idx_ff <= SW'(iss_ff);
               end else begin
                  cmp_vld_ff <= 1'b0;
               end
               if (hit) begin
                  unique case (mode_ff)
                     M_LOOKUP: begin
                        res_ff.status <= ST_OK;
                        res_ff.slot   <= 4'(cmp_idx_ff);
                        state_ff      <= S_FINISH;
                     end
                     M_INUSE: begin
                        res_ff.status     <= ST_PORT_USED;
                        res_ff.local_port <= tgt_ff;
                        state_ff          <= S_FINISH;
                     end
                     default: begin
                        if (eph_ff == start_ff) begin
                           res_ff.status <= ST_NO_FREE;
                           state_ff      <= S_FINISH;
                        end else begin
                           // Candidate taken: move on to the next one and rescan.
                           tgt_ff     <= eph_ff;
                           eph_ff     <= eph_adv;
                           iss_ff     <= '0;
                           cmp_vld_ff <= 1'b0;
                        end
                     end
                  endcase
               end else if (scan_end) begin
                  state_ff <= S_FINISH;
                  if (mode_ff == M_LOOKUP) begin
                     res_ff.status <= ST_NO_LISTEN;
                  end else begin
                     valid_ff[job_si]  <= 1'b1;
                     res_ff.status     <= ST_OK;
                     res_ff.local_port <= tgt_ff;
                  end
               end
            end
            S_UNB_RD: begin
               valid_ff[job_si]  <= 1'b0;
               res_ff.status     <= ST_OK;
               res_ff.local_port <= rd_data_ff;
               state_ff          <= S_FINISH;
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Payload length register that the datagram path does not otherwise read.
   logic unused_plen;
   assign unused_plen = ^plen_ff;

endmodule
